>>> hw/rtl/jfgs_pkg.sv
// Shared types and constants of the join, filter and group-sum block.
package jfgs_pkg;

    // Store sizes.
    localparam int SUP_ENTRIES  = 16384;
    localparam int PART_ENTRIES = 262144;
    localparam int SUP_AW       = $clog2(SUP_ENTRIES);
    localparam int PART_AW      = $clog2(PART_ENTRIES);

    // The clearing pass walks the larger of the two stores.
    localparam int CLR_ENTRIES  = (SUP_ENTRIES > PART_ENTRIES) ? SUP_ENTRIES : PART_ENTRIES;
    localparam int CLR_AW       = $clog2(CLR_ENTRIES);

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int SKEY_W   = 14;
    localparam int NATION_W = 8;
    localparam int PKEY_W   = 19;
    localparam int QTY_W    = 14;
    localparam int COST_W   = 17;
    localparam int PROD_W   = 31;
    localparam int SUM_W    = 64;
    localparam int VALUE_W  = 63;

    // Configuration port.
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic [0:0] REG_NATION_KEY = 1'b0;

    // Function codes of an input transaction.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_JOIN = 2'd1,
        FUNC_READ = 2'd2
    } func_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Write request into the supplier table.
    typedef struct packed {
        logic                en;
        logic [SUP_AW-1:0]   idx;
        logic                valid;
        logic [NATION_W-1:0] nation;
    } sup_wr_t;

endpackage

>>> hw/rtl/join_filter_group_sum.sv
// Top level of the join, filter and group-sum block.
//
// A transaction is taken at a rising edge with start high and busy low. The
// accept edge reads the supplier table and the part-sum memory (both
// synchronous, with registered reads) and registers the cost times quantity
// product; the following edge writes the loaded supplier or the updated part
// sum back, so busy is high for the one cycle in between. A readout raises
// done for one cycle right after that, carrying the part key and the low 63
// bits of its sum; the receiver cannot stall it, and a new transaction may be
// accepted in the same cycle. After reset a clearing pass zeroes the part-sum
// memory and the supplier valid bits, one entry per cycle over all 262144
// entries, with busy high. Register writes are taken at any time.
module join_filter_group_sum (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jfgs_pkg::APB_AW-1:0]     paddr,
    input  logic [jfgs_pkg::APB_DW-1:0]     pwdata,
    output logic [jfgs_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    // Command side
    input  logic                            start,
    output logic                            busy,
    input  logic [jfgs_pkg::FUNC_W-1:0]     func,
    input  logic [jfgs_pkg::SKEY_W-1:0]     supplier_key,
    input  logic [jfgs_pkg::NATION_W-1:0]   supplier_nation,
    input  logic [jfgs_pkg::PKEY_W-1:0]     part_key,
    input  logic [jfgs_pkg::QTY_W-1:0]      avail_qty,
    input  logic [jfgs_pkg::COST_W-1:0]     supply_cost,
    // Result side
    output logic                            done,
    output logic [jfgs_pkg::PKEY_W-1:0]     read_part,
    output logic [jfgs_pkg::VALUE_W-1:0]    part_value
);
    import jfgs_pkg::*;

    localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_ENTRIES - 1);

    state_t                state_reg, state_next;
    logic [CLR_AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [NATION_W-1:0]   nation_key_reg, nation_key_next;
    logic                  done_reg, done_next;
    logic [PKEY_W-1:0]     read_part_reg, read_part_next;
    logic [VALUE_W-1:0]    part_value_reg, part_value_next;

    // Captured transaction
    func_t                 func_reg;
    logic                  sup_ok_reg;
    logic                  part_ok_reg;
    logic [SUP_AW-1:0]     sup_idx_reg;
    logic [NATION_W-1:0]   nation_reg;
    logic [PART_AW-1:0]    part_idx_reg;
    logic [PKEY_W-1:0]     part_key_reg;
    logic [PROD_W-1:0]     prod_reg;

    logic                  accept;
    logic                  cfg_wr;
    logic                  sup_ok;
    logic                  part_ok;
    logic [SUP_AW-1:0]     sup_idx;
    logic [PART_AW-1:0]    part_idx;
    logic                  sup_hit;
    sup_wr_t               sup_wr;

    // Part-sum memory
    logic [SUM_W-1:0]      part_mem [PART_ENTRIES];
    logic [SUM_W-1:0]      part_rd_reg;
    logic                  part_we;
    logic [PART_AW-1:0]    part_widx;
    logic [SUM_W-1:0]      part_wdata;

    // Handshakes and key decode
    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign sup_ok   = (32'(supplier_key) < SUP_ENTRIES);
    assign part_ok  = (part_key != '0) && (32'(part_key) <= PART_ENTRIES);
    assign sup_idx  = SUP_AW'(supplier_key);
    assign part_idx = PART_AW'(part_key - PKEY_W'(1));

    // Configuration register and read-back
    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_NATION_KEY) ?
                    APB_DW'(nation_key_reg) : '0;

    always_comb
    begin
        nation_key_next = nation_key_reg;
        if (cfg_wr && (paddr[2:2] == REG_NATION_KEY))
        begin
            nation_key_next = pwdata[NATION_W-1:0];
        end
    end

    // Supplier table
    jfgs_sup_table u_sup_table (
        .clk        (clk),
        .rd_en      (accept),
        .rd_idx     (sup_idx),
        .wr         (sup_wr),
        .nation_key (nation_key_reg),
        .hit        (sup_hit)
    );

    // Sequencer: clearing pass, then accept and write-back per transaction.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        done_next       = 1'b0;
        read_part_next  = read_part_reg;
        part_value_next = part_value_reg;
        sup_wr          = '0;
        part_we         = 1'b0;
        part_widx       = part_idx_reg;
        part_wdata      = part_rd_reg + SUM_W'(prod_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                sup_wr.en    = (32'(clr_cnt_reg) < SUP_ENTRIES);
                sup_wr.idx   = SUP_AW'(clr_cnt_reg);
                sup_wr.valid = 1'b0;
                part_we      = (32'(clr_cnt_reg) < PART_ENTRIES);
                part_widx    = PART_AW'(clr_cnt_reg);
                part_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + CLR_AW'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (func_reg)
                    FUNC_LOAD:
                    begin
                        sup_wr.en     = sup_ok_reg;
                        sup_wr.idx    = sup_idx_reg;
                        sup_wr.valid  = 1'b1;
                        sup_wr.nation = nation_reg;
                    end
                    FUNC_JOIN:
                    begin
                        part_we = sup_ok_reg && sup_hit && part_ok_reg;
                    end
                    FUNC_READ:
                    begin
                        done_next       = part_ok_reg;
                        read_part_next  = part_key_reg;
                        part_value_next = part_rd_reg[VALUE_W-1:0];
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            nation_key_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            nation_key_reg <= nation_key_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers: the accepted transaction and the outgoing result.
    always_ff @(posedge clk)
    begin
        read_part_reg  <= read_part_next;
        part_value_reg <= part_value_next;
        if (accept)
        begin
            func_reg     <= func_t'(func);
            sup_ok_reg   <= sup_ok;
            part_ok_reg  <= part_ok;
            sup_idx_reg  <= sup_idx;
            nation_reg   <= supplier_nation;
            part_idx_reg <= part_idx;
            part_key_reg <= part_key;
            prod_reg     <= PROD_W'(supply_cost) * PROD_W'(avail_qty);
        end
    end

    // Part-sum memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (part_we)
        begin
            part_mem[part_widx] <= part_wdata;
        end
        if (accept)
        begin
            part_rd_reg <= part_mem[part_idx];
        end
    end

    assign done       = done_reg;
    assign read_part  = read_part_reg;
    assign part_value = part_value_reg;

`ifndef ASSERT_OFF
    // A result only follows the write-back cycle of a readout.
    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC && func_reg == FUNC_READ))
        else $error("result strobe without a readout");

    // Outside the clearing pass the part sums change only for a joined row.
    a_part_write_join: assert property (@(posedge clk) disable iff (!rst_n)
        (part_we && state_reg != ST_CLEAR) |->
        (func_reg == FUNC_JOIN && part_ok_reg && sup_ok_reg))
        else $error("part sum written without a joined row");

    // The clearing pass ends only after its last entry.
    a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR && $past(state_reg == ST_CLEAR)) |->
        ($past(clr_cnt_reg) == CLR_LAST))
        else $error("clearing pass left early");
`endif

endmodule

>>> hw/rtl/jfgs_sup_table.sv
// Supplier table: direct-mapped memory from supplier key to valid bit and nation.
module jfgs_sup_table (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [jfgs_pkg::SUP_AW-1:0]    rd_idx,
    input  jfgs_pkg::sup_wr_t              wr,
    input  logic [jfgs_pkg::NATION_W-1:0]  nation_key,
    output logic                           hit
);
    import jfgs_pkg::*;

    logic [NATION_W:0] mem [SUP_ENTRIES];
    logic [NATION_W:0] rd_word_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= {wr.valid, wr.nation};
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_idx];
        end
    end

    // The supplier joins when it was loaded and belongs to the selected nation.
    assign hit = rd_word_reg[NATION_W] && (rd_word_reg[NATION_W-1:0] == nation_key);

endmodule
